// ===== src/assert_macros.svh =====
// Assertion macros shared by the altitude integrator RTL.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Fail when cond is ever true outside reset.
`define BAI_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: condition must never hold");

// Fail when a holds and b does not hold in the same cycle.
`define BAI_ASSERT_IMPLY(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Fail when a holds and b does not hold in the next cycle.
`define BAI_ASSERT_IMPLY_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/bai_pkg.sv =====
// Shared types and fixed constants of the barometric altitude integrator.
// No dependencies; imported by every module of the block.
package bai_pkg;

  localparam int TEMP_W   = 14;  // raw temperature, degC * 20
  localparam int START_W  = 16;  // start altitude in metres
  localparam int ALT_W    = 32;  // running altitude in mm
  localparam int TSUM_W   = 15;  // temperature plus kelvin offset
  localparam int K_W      = 26;  // signed scale term (tsum * 1463)
  localparam int K_MAG_W  = 25;  // magnitude of the scale term
  localparam int START_MM_W = 27;

  localparam logic signed [TSUM_W-1:0] KELVIN_OFFSET_X20 = 15'sd5463;
  localparam logic signed [11:0]       MM_SCALE_FACTOR   = 12'sd1463;
  localparam logic signed [10:0]       MM_PER_METRE      = 11'sd1000;

  // Handshake status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } bai_unit_sts_t;

endpackage

// ===== src/bai_mul.sv =====
// Bit-serial shift-and-add multiplier for the scale term times pressure delta.
// Depends on bai_pkg. One multiplier bit per cycle, over all PRESSURE_WIDTH multiplier bits.
module bai_mul #(
  parameter int PRESSURE_WIDTH = 19
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              start,
  input  logic [bai_pkg::K_MAG_W-1:0]                       a_mag,
  input  logic [PRESSURE_WIDTH-1:0]                         b_mag,
  output bai_pkg::bai_unit_sts_t                            sts,
  output logic [bai_pkg::K_MAG_W+PRESSURE_WIDTH-1:0]        product
);
  import bai_pkg::*;

  localparam int CNT_W = $clog2(PRESSURE_WIDTH + 1);

  logic [K_MAG_W-1:0]        mcand;
  logic [K_MAG_W-1:0]        hi;
  logic [PRESSURE_WIDTH-1:0] lo;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;
  logic [K_MAG_W:0]          sum;

  // Add the multiplicand when the current multiplier bit is set.
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PRESSURE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a_mag;
      hi    <= '0;
      lo    <= b_mag;
    end else if (busy) begin
      // Shift the partial product right one bit.
      hi <= sum[K_MAG_W:1];
      lo <= {sum[0], lo[PRESSURE_WIDTH-1:1]};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign product  = {hi, lo};

endmodule

// ===== src/bai_div.sv =====
// Radix-2 restoring divider for the product magnitude over the reference.
// Depends on bai_pkg. One quotient bit per cycle over the full dividend width.
module bai_div #(
  parameter int PRESSURE_WIDTH = 19
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic [bai_pkg::K_MAG_W+PRESSURE_WIDTH-1:0]  dividend,
  input  logic [PRESSURE_WIDTH-1:0]                   divisor,
  output bai_pkg::bai_unit_sts_t                      sts,
  output logic [bai_pkg::ALT_W-1:0]                   quotient
);
  import bai_pkg::*;

  localparam int PROD_W = K_MAG_W + PRESSURE_WIDTH;
  localparam int CNT_W  = $clog2(PROD_W + 1);

  logic [PRESSURE_WIDTH-1:0] rem;
  logic [PRESSURE_WIDTH-1:0] dsr;
  logic [PROD_W-1:0]         qd;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;
  logic [PRESSURE_WIDTH:0]   trial;
  logic [PRESSURE_WIDTH:0]   trial_sub;
  logic                      fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial     = {rem, qd[PROD_W-1]};
  assign trial_sub = trial - {1'b0, dsr};
  assign fits      = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PROD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      qd  <= dividend;
    end else if (busy) begin
      rem <= fits ? trial_sub[PRESSURE_WIDTH-1:0] : trial[PRESSURE_WIDTH-1:0];
      qd  <= {qd[PROD_W-2:0], fits};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  // Only the low word is kept; the altitude wraps at 32 bits.
  assign quotient = qd[ALT_W-1:0];

endmodule

// ===== src/baro_altitude_integrator_unit.sv =====
// Barometric differential altitude integrator, top level (uses bai_pkg, bai_mul,
// bai_div and assert_macros.svh). Each input beat carries one barometer sample
// (pressure in Pa*4, temperature in degC*20). The block keeps the previous
// pressure as a reference and, when that reference is nonzero, adds
// ((temperature + 5463) * 1463 * (reference - pressure)) / reference to a
// 32-bit wrapping altitude in millimetres, truncating toward zero; the sample
// pressure then becomes the new reference. Every sample yields exactly one
// output beat with the updated altitude and a flag telling whether an
// increment was added. A sample with a reference passes first through the
// bit-serial multiplier, then through the radix-2 divider, and then waits
// for the output register; a sample without a reference skips both units and
// waits for the output register directly. Only one sample is in flight; the
// output register lets the next sample start while a result waits downstream.
// Writing cfg_data (start altitude in metres) loads the altitude with
// cfg_data * 1000 and drops the reference; cfg_ready is high only when the
// block is idle, and a waiting write holds the sample input off so the
// write always lands before the next sample.
`include "assert_macros.svh"

module baro_altitude_integrator_unit #(
  parameter int PRESSURE_WIDTH = 19
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [PRESSURE_WIDTH-1:0]           pressure_raw,
  input  logic signed [bai_pkg::TEMP_W-1:0]   temperature_raw,
  // result output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bai_pkg::ALT_W-1:0]    altitude_mm,
  output logic                                had_reference,
  // start altitude register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic signed [bai_pkg::START_W-1:0]  cfg_data
);
  import bai_pkg::*;

  localparam int PROD_W = K_MAG_W + PRESSURE_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Architectural state.
  logic [PRESSURE_WIDTH-1:0]  ref_p;
  logic [ALT_W-1:0]           acc;
  logic [ALT_W-1:0]           acc_next;

  // Per-sample working registers.
  logic [PRESSURE_WIDTH-1:0]  divisor;
  logic                       q_neg;
  logic                       had;
  logic [ALT_W-1:0]           inc;

  // Handshake strobes.
  logic in_accept;
  logic cfg_wr;
  logic out_load;
  logic mul_start;

  // Operand preparation.
  logic signed [TSUM_W-1:0]         tsum;
  logic signed [K_W-1:0]            k_full;
  logic                             k_neg;
  logic [K_W-1:0]                   k_abs;
  logic signed [PRESSURE_WIDTH:0]   diff;
  logic                             d_neg;
  logic [PRESSURE_WIDTH:0]          d_abs;
  logic signed [START_MM_W-1:0]     start_mm;

  // Unit connections.
  bai_unit_sts_t               mul_sts;
  bai_unit_sts_t               div_sts;
  logic [PROD_W-1:0]           product;
  logic [ALT_W-1:0]            q_low;

  // Hold the sample input off while a register write waits.
  assign in_stall  = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign mul_start = in_accept && (ref_p != '0);
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  // Scale term: (temperature + kelvin offset) * 1463, split into sign and magnitude.
  assign tsum   = TSUM_W'(temperature_raw) + KELVIN_OFFSET_X20;
  assign k_full = tsum * MM_SCALE_FACTOR;
  assign k_neg  = k_full[K_W-1];
  assign k_abs  = k_neg ? K_W'(-k_full) : K_W'(k_full);

  // Pressure drop since the reference; its magnitude fits PRESSURE_WIDTH bits.
  assign diff  = $signed({1'b0, ref_p}) - $signed({1'b0, pressure_raw});
  assign d_neg = diff[PRESSURE_WIDTH];
  assign d_abs = d_neg ? (PRESSURE_WIDTH + 1)'(-diff) : (PRESSURE_WIDTH + 1)'(diff);

  assign start_mm = cfg_data * MM_PER_METRE;

  assign acc_next = had ? (acc + inc) : acc;

  bai_mul #(
    .PRESSURE_WIDTH(PRESSURE_WIDTH)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a_mag   (k_abs[K_MAG_W-1:0]),
    .b_mag   (d_abs[PRESSURE_WIDTH-1:0]),
    .sts     (mul_sts),
    .product (product)
  );

  bai_div #(
    .PRESSURE_WIDTH(PRESSURE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_sts.done),
    .dividend (product),
    .divisor  (divisor),
    .sts      (div_sts),
    .quotient (q_low)
  );

  // Sequencer: multiply, divide (both skipped without a reference), then hold until the output register is free.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (ref_p != '0) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        if (mul_sts.done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ref_p     <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Load the start altitude and drop the reference.
      if (cfg_wr) begin
        acc   <= ALT_W'(start_mm);
        ref_p <= '0;
      end
      // The sample pressure becomes the reference for the next beat.
      if (in_accept) begin
        ref_p <= pressure_raw;
      end
      if (out_load) begin
        acc       <= acc_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      divisor <= ref_p;
      had     <= (ref_p != '0);
      q_neg   <= k_neg ^ d_neg;
    end
    // Restore the sign of the truncated quotient.
    if (div_sts.done) begin
      inc <= q_neg ? (~q_low + 1'b1) : q_low;
    end
    if (out_load) begin
      altitude_mm   <= acc_next;
      had_reference <= had;
    end
  end

  `BAI_ASSERT_NEVER(a_units_overlap, mul_sts.busy && div_sts.busy)
  `BAI_ASSERT_IMPLY(a_busy_stalls, mul_sts.busy || div_sts.busy, in_stall)
  `BAI_ASSERT_IMPLY(a_divisor_nonzero, state == ST_DIV, divisor != '0)
  `BAI_ASSERT_IMPLY_NEXT(a_no_ref_skips, in_accept && ref_p == '0, state == ST_DONE && !had)

endmodule
